>>> sv/mcbp_pkg.sv
// shared types, codes and constants of the multi-channel byte pipe
package mcbp_pkg;

   // default geometry
   localparam int DEF_CHANNELS  = 8;
   localparam int DEF_BUF_DEPTH = 256;

   // capacity register width, set by the requested_size field
   localparam int CAP_W = 9;
   localparam logic [CAP_W-1:0] SIZE_LOW_MASK = 9'h00F;

   // function codes
   localparam logic [2:0] FN_OPEN    = 3'd0;
   localparam logic [2:0] FN_RELEASE = 3'd1;
   localparam logic [2:0] FN_WRITE   = 3'd2;
   localparam logic [2:0] FN_READ    = 3'd3;
   localparam logic [2:0] FN_QUERY   = 3'd4;

   // status codes
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_EMPTY    = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_BAD_SIZE = 3'd3;
   localparam logic [2:0] STAT_NO_FREE  = 3'd4;
   localparam logic [2:0] STAT_NOT_OPEN = 3'd5;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_MEMRD,
      S_DONE
   } fsm_state_type;

   // channel table update operations
   typedef enum logic [2:0] {
      TBL_NOP,
      TBL_OPEN,
      TBL_RELEASE,
      TBL_ADV_WR,
      TBL_ADV_RD
   } tbl_op_type;

   typedef struct packed {
      tbl_op_type       op;
      logic [CAP_W-1:0] cap;
   } tbl_cmd_type;

   // state of the selected channel as seen by the sequencer
   typedef struct packed {
      logic             open;
      logic             full;
      logic             empty;
      logic [CAP_W-1:0] ready;
   } tbl_view_type;

   // request transaction
   typedef struct packed {
      logic [2:0] func;
      logic [2:0] channel;
      logic [7:0] data_in;
      logic [8:0] requested_size;
      logic       last_of_transfer;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [7:0] data_out;
      logic [2:0] status;
      logic [2:0] channel_out;
      logic [7:0] fill_level;
      logic       end_of_transfer;
   } rsp_type;

endpackage

>>> sv/mcbp_byte_ram.sv
// byte storage for all pipes, one access per cycle, registered read
module mcbp_byte_ram import mcbp_pkg::*; #(
   parameter int CHANNELS  = DEF_CHANNELS,
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
   input  logic                                           clock,
   input  logic                                           we,
   input  logic                                           re,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] chan,
   input  logic [$clog2(BUF_DEPTH)-1:0]                   ptr,
   input  logic [7:0]                                     wdata,
   output logic [7:0]                                     rdata
);

   localparam int DEPTH  = CHANNELS * BUF_DEPTH;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rdata_ff;
   logic [ADDR_W-1:0] addr;

   // channel base plus ring offset
   assign addr = ADDR_W'(ADDR_W'(chan) * ADDR_W'(BUF_DEPTH)) + ADDR_W'(ptr);

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/mcbp_chan_table.sv
// per-channel pointers, capacity and open count with one shared fill unit
module mcbp_chan_table import mcbp_pkg::*; #(
   parameter int CHANNELS  = DEF_CHANNELS,
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] idx,
   input  logic                                           idx_ok,
   input  tbl_cmd_type                                    cmd,
   output tbl_view_type                                   view,
   output logic [$clog2(BUF_DEPTH)-1:0]                   rd_ptr,
   output logic [$clog2(BUF_DEPTH)-1:0]                   wr_ptr
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W = $clog2(BUF_DEPTH);
   localparam int CNT_W = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;

   logic [PTR_W-1:0] rd_ptr_ff [CHANNELS];
   logic [PTR_W-1:0] rd_ptr_in [CHANNELS];
   logic [PTR_W-1:0] wr_ptr_ff [CHANNELS];
   logic [PTR_W-1:0] wr_ptr_in [CHANNELS];
   logic [CAP_W-1:0] cap_ff    [CHANNELS];
   logic [CAP_W-1:0] cap_in    [CHANNELS];
   logic [7:0]       cnt_ff    [CHANNELS];
   logic [7:0]       cnt_in    [CHANNELS];

   logic [CH_W-1:0]  sidx;
   logic [CNT_W-1:0] r_ext;
   logic [CNT_W-1:0] w_ext;
   logic [CNT_W-1:0] c_ext;
   logic [CNT_W-1:0] ready_ext;
   logic [CNT_W-1:0] r_inc;
   logic [CNT_W-1:0] w_inc;
   logic [PTR_W-1:0] r_next;
   logic [PTR_W-1:0] w_next;
   logic             is_open;

   // keep the selected entry inside the table
   assign sidx = (32'(idx) < CHANNELS) ? idx : '0;

   assign r_ext = CNT_W'(rd_ptr_ff[sidx]);
   assign w_ext = CNT_W'(wr_ptr_ff[sidx]);
   assign c_ext = CNT_W'(cap_ff[sidx]);

   // shared fill unit: bytes ready in the selected ring
   assign ready_ext = (w_ext >= r_ext) ? (w_ext - r_ext) : (c_ext - r_ext + w_ext);

   // pointer advance with wrap at capacity
   assign r_inc  = r_ext + CNT_W'(1);
   assign w_inc  = w_ext + CNT_W'(1);
   assign r_next = (r_inc >= c_ext) ? '0 : PTR_W'(r_inc);
   assign w_next = (w_inc >= c_ext) ? '0 : PTR_W'(w_inc);

   assign is_open = idx_ok && (cnt_ff[sidx] != 8'd0);

   assign view.open  = is_open;
   assign view.ready = CAP_W'(ready_ext);
   assign view.empty = (ready_ext == '0);
   assign view.full  = (ready_ext >= (c_ext - CNT_W'(1)));
   assign rd_ptr     = rd_ptr_ff[sidx];
   assign wr_ptr     = wr_ptr_ff[sidx];

   // next value of each entry
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         rd_ptr_in[i] = rd_ptr_ff[i];
         wr_ptr_in[i] = wr_ptr_ff[i];
         cap_in[i]    = cap_ff[i];
         cnt_in[i]    = cnt_ff[i];
         if (CH_W'(i) == sidx) begin
            case (cmd.op)
               TBL_OPEN: begin
                  rd_ptr_in[i] = '0;
                  wr_ptr_in[i] = '0;
                  cap_in[i]    = cmd.cap;
                  cnt_in[i]    = 8'd1;
               end
               TBL_RELEASE: begin
                  cnt_in[i] = cnt_ff[i] - 8'd1;
                  if (cnt_ff[i] == 8'd1) begin
                     rd_ptr_in[i] = '0;
                     wr_ptr_in[i] = '0;
                     cap_in[i]    = '0;
                  end
               end
               TBL_ADV_WR: wr_ptr_in[i] = w_next;
               TBL_ADV_RD: rd_ptr_in[i] = r_next;
               default: ;
            endcase
         end
      end
   end

   // table registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            cap_ff[i]    <= '0;
            cnt_ff[i]    <= '0;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            rd_ptr_ff[i] <= rd_ptr_in[i];
            wr_ptr_ff[i] <= wr_ptr_in[i];
            cap_ff[i]    <= cap_in[i];
            cnt_ff[i]    <= cnt_in[i];
         end
      end
   end

endmodule

>>> sv/mcbp_ctrl.sv
// sequencer: request capture, free-channel scan, table and memory steps
module mcbp_ctrl import mcbp_pkg::*; #(
   parameter int CHANNELS  = DEF_CHANNELS,
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_stall,
   input  req_type                                        req_data,
   input  tbl_view_type                                   view,
   input  logic [$clog2(BUF_DEPTH)-1:0]                   rd_ptr,
   input  logic [$clog2(BUF_DEPTH)-1:0]                   wr_ptr,
   output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] idx,
   output logic                                           idx_ok,
   output tbl_cmd_type                                    cmd,
   output logic                                           ram_we,
   output logic                                           ram_re,
   output logic [$clog2(BUF_DEPTH)-1:0]                   ram_ptr,
   output logic [7:0]                                     ram_wdata,
   input  logic [7:0]                                     ram_rdata,
   input  logic                                           out_busy,
   output logic                                           done,
   output rsp_type                                        result
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   fsm_state_type   state_ff, state_in;
   req_type         req_ff, req_in;
   logic [CH_W-1:0] scan_ff, scan_in;
   logic [CH_W-1:0] sel_ff, sel_in;
   logic            sel_ok_ff, sel_ok_in;
   logic [2:0]      status_ff, status_in;
   logic [2:0]      chout_ff, chout_in;
   logic [7:0]      dout_ff, dout_in;

   logic             accept;
   logic [CAP_W-1:0] size;
   logic             size_bad;
   logic             scan_last;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   // capacity from the request with the low bits cleared
   assign size      = req_ff.requested_size & ~SIZE_LOW_MASK;
   assign size_bad  = (32'(size) <= 1) || (32'(size) > BUF_DEPTH);
   assign scan_last = (scan_ff == CH_W'(CHANNELS - 1));

   // table entry in view: scan pointer during open, else addressed channel
   assign idx       = (state_ff == S_SCAN) ? scan_ff : sel_ff;
   assign idx_ok    = (state_ff == S_SCAN) || sel_ok_ff;
   assign ram_wdata = req_ff.data_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_data.func == FN_OPEN) ? S_SCAN : S_EXEC;
            end
         end
         S_SCAN: begin
            if (!view.open || scan_last) begin
               state_in = S_DONE;
            end
         end
         S_EXEC: begin
            if (view.open && (req_ff.func == FN_READ) && !view.empty) begin
               state_in = S_MEMRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MEMRD: state_in = S_DONE;
         S_DONE: begin
            if (!out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath controls and next values
   always_comb begin
      req_in    = req_ff;
      scan_in   = scan_ff;
      sel_in    = sel_ff;
      sel_ok_in = sel_ok_ff;
      status_in = status_ff;
      chout_in  = chout_ff;
      dout_in   = dout_ff;
      cmd.op    = TBL_NOP;
      cmd.cap   = size;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_ptr   = wr_ptr;
      done      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               scan_in   = '0;
               sel_in    = CH_W'(req_data.channel);
               sel_ok_in = (32'(req_data.channel) < CHANNELS);
               status_in = STAT_OK;
               chout_in  = req_data.channel;
               dout_in   = 8'd0;
            end
         end
         // one table entry per cycle looking for a free channel
         S_SCAN: begin
            if (!view.open) begin
               if (size_bad) begin
                  status_in = STAT_BAD_SIZE;
               end else begin
                  cmd.op    = TBL_OPEN;
                  sel_in    = scan_ff;
                  sel_ok_in = 1'b1;
                  chout_in  = 3'(scan_ff);
               end
            end else if (scan_last) begin
               status_in = STAT_NO_FREE;
            end else begin
               scan_in = CH_W'(scan_ff + 1'b1);
            end
         end
         S_EXEC: begin
            if (!view.open) begin
               status_in = STAT_NOT_OPEN;
            end else begin
               case (req_ff.func)
                  FN_RELEASE: cmd.op = TBL_RELEASE;
                  FN_WRITE: begin
                     if (view.full) begin
                        status_in = STAT_FULL;
                     end else begin
                        cmd.op  = TBL_ADV_WR;
                        ram_we  = 1'b1;
                        ram_ptr = wr_ptr;
                     end
                  end
                  FN_READ: begin
                     if (view.empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        cmd.op  = TBL_ADV_RD;
                        ram_re  = 1'b1;
                        ram_ptr = rd_ptr;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MEMRD: dout_in = ram_rdata;
         S_DONE:  done = !out_busy;
         default: ;
      endcase
   end

   // response fields, fill level from the table after the update
   assign result.data_out        = dout_ff;
   assign result.status          = status_ff;
   assign result.channel_out     = chout_ff;
   assign result.fill_level      = view.open ? 8'(view.ready) : 8'd0;
   assign result.end_of_transfer = req_ff.last_of_transfer;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // transaction registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      scan_ff   <= scan_in;
      sel_ff    <= sel_in;
      sel_ok_ff <= sel_ok_in;
      status_ff <= status_in;
      chout_ff  <= chout_in;
      dout_ff   <= dout_in;
   end

endmodule

>>> sv/multi_channel_byte_pipe_unit.sv
// top level of the multi-channel byte pipe with response register
//
// A table of byte pipes, each a ring buffer in a shared byte memory that
// keeps one slot empty. Requests arrive on req_valid/req_stall/req_data and
// give exactly one response on rsp_valid/rsp_stall/rsp_data. A transaction
// moves when valid is high and stall is low.
// Open scans the table one channel per cycle for a free entry; release,
// write, read and query take one table step. A sequencer works on one
// request at a time and stalls the request side meanwhile.
// From acceptance, release, write and query pass one execute step and a
// done step; read adds a step for the registered memory read, and open
// scans from one up to CHANNELS table entries before its done step.
// The next request is taken in the cycle after the response is loaded.
// Reset clears the sequencer state, the response valid flag and every channel
// entry, so all channels are free; the byte memory is not cleared.
// While the receiver stalls, the response holds and the next request may
// be accepted and worked on; it waits in its final step until the response
// register is free.
module multi_channel_byte_pipe_unit import mcbp_pkg::*; #(
   parameter int CHANNELS  = DEF_CHANNELS,
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W = $clog2(BUF_DEPTH);

   tbl_view_type     view;
   tbl_cmd_type      cmd;
   logic [CH_W-1:0]  idx;
   logic             idx_ok;
   logic [PTR_W-1:0] rd_ptr;
   logic [PTR_W-1:0] wr_ptr;
   logic             ram_we;
   logic             ram_re;
   logic [PTR_W-1:0] ram_ptr;
   logic [7:0]       ram_wdata;
   logic [7:0]       ram_rdata;
   logic             out_busy;
   logic             done;
   rsp_type          result;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   mcbp_ctrl #(
      .CHANNELS  (CHANNELS),
      .BUF_DEPTH (BUF_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .view      (view),
      .rd_ptr    (rd_ptr),
      .wr_ptr    (wr_ptr),
      .idx       (idx),
      .idx_ok    (idx_ok),
      .cmd       (cmd),
      .ram_we    (ram_we),
      .ram_re    (ram_re),
      .ram_ptr   (ram_ptr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata),
      .out_busy  (out_busy),
      .done      (done),
      .result    (result)
   );

   mcbp_chan_table #(
      .CHANNELS  (CHANNELS),
      .BUF_DEPTH (BUF_DEPTH)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .idx    (idx),
      .idx_ok (idx_ok),
      .cmd    (cmd),
      .view   (view),
      .rd_ptr (rd_ptr),
      .wr_ptr (wr_ptr)
   );

   mcbp_byte_ram #(
      .CHANNELS  (CHANNELS),
      .BUF_DEPTH (BUF_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .chan  (idx),
      .ptr   (ram_ptr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // response register
   assign out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/multi_channel_byte_pipe_checker.sv
// response checker for the multi-channel byte pipe: predicts and compares every transaction
`timescale 1ns / 1ps

module multi_channel_byte_pipe_checker import mcbp_pkg::*; #(
   parameter int CHANNELS  = DEF_CHANNELS,
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_count
);

   localparam int REPORT_LIMIT = 10;

   // shadow pipe table
   logic [7:0]  pipe_bytes [CHANNELS][BUF_DEPTH];
   int unsigned rd_ptr     [CHANNELS];
   int unsigned wr_ptr     [CHANNELS];
   int unsigned capacity   [CHANNELS];
   int unsigned open_cnt   [CHANNELS];

   // responses predicted but not yet seen, oldest first
   rsp_type awaited_rsp [$];

   // bytes waiting in a channel, zero when it is not open
   function automatic int unsigned fill_bytes(input int unsigned ch);
      if (ch >= CHANNELS || open_cnt[ch] == 0) return 0;
      if (wr_ptr[ch] >= rd_ptr[ch]) return wr_ptr[ch] - rd_ptr[ch];
      return capacity[ch] - rd_ptr[ch] + wr_ptr[ch];
   endfunction

   // apply one request to the shadow table and return its response
   function automatic rsp_type pipe_op_result(input req_type rq);
      rsp_type     rs;
      int unsigned ch;
      int unsigned free_ch;
      int unsigned size;
      ch                 = 32'(rq.channel);
      rs                 = '0;
      rs.status          = STAT_OK;
      rs.channel_out     = rq.channel;
      rs.end_of_transfer = rq.last_of_transfer;
      if (rq.func == FN_OPEN) begin
         // lowest free channel wins; the free check comes before the size check
         free_ch = CHANNELS;
         for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (open_cnt[i] == 0) free_ch = i;
         end
         size = 32'(rq.requested_size & ~SIZE_LOW_MASK);
         if (free_ch == CHANNELS) begin
            rs.status = STAT_NO_FREE;
         end else if (size <= 1 || size > BUF_DEPTH) begin
            rs.status = STAT_BAD_SIZE;
         end else begin
            capacity[free_ch] = size;
            rd_ptr[free_ch]   = 0;
            wr_ptr[free_ch]   = 0;
            open_cnt[free_ch] = 1;
            rs.channel_out    = 3'(free_ch);
         end
      end else if (ch >= CHANNELS || open_cnt[ch] == 0) begin
         rs.status = STAT_NOT_OPEN;
      end else begin
         case (rq.func)
            FN_RELEASE: begin
               open_cnt[ch] = open_cnt[ch] - 1;
               if (open_cnt[ch] == 0) begin
                  capacity[ch] = 0;
                  rd_ptr[ch]   = 0;
                  wr_ptr[ch]   = 0;
               end
            end
            FN_WRITE: begin
               // one slot always stays empty
               if (fill_bytes(ch) >= capacity[ch] - 1) begin
                  rs.status = STAT_FULL;
               end else begin
                  pipe_bytes[ch][wr_ptr[ch]] = rq.data_in;
                  wr_ptr[ch] = (wr_ptr[ch] + 1 >= capacity[ch]) ? 0 : wr_ptr[ch] + 1;
               end
            end
            FN_READ: begin
               if (fill_bytes(ch) == 0) begin
                  rs.status = STAT_EMPTY;
               end else begin
                  rs.data_out = pipe_bytes[ch][rd_ptr[ch]];
                  rd_ptr[ch]  = (rd_ptr[ch] + 1 >= capacity[ch]) ? 0 : rd_ptr[ch] + 1;
               end
            end
            // query and spare codes leave the table alone
            default: ;
         endcase
      end
      rs.fill_level = 8'(fill_bytes(32'(rs.channel_out)));
      return rs;
   endfunction

   // watch both channels at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            rd_ptr[c]   = 0;
            wr_ptr[c]   = 0;
            capacity[c] = 0;
            open_cnt[c] = 0;
         end
         awaited_rsp.delete();
         mismatch_count = 0;
      end else begin
         // response side first, so a response never meets its own request
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected response data=%h status=%0d ch=%0d fill=%0d eot=%0b",
                           $realtime, rsp_data.data_out, rsp_data.status,
                           rsp_data.channel_out, rsp_data.fill_level,
                           rsp_data.end_of_transfer);
            end else begin
               want = awaited_rsp.pop_front();
               if (want.data_out        !== rsp_data.data_out    ||
                   want.status          !== rsp_data.status      ||
                   want.channel_out     !== rsp_data.channel_out ||
                   want.fill_level      !== rsp_data.fill_level  ||
                   want.end_of_transfer !== rsp_data.end_of_transfer) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: expected data=%h status=%0d ch=%0d fill=%0d eot=%0b, %s",
                              $realtime, want.data_out, want.status, want.channel_out,
                              want.fill_level, want.end_of_transfer,
                              $sformatf("got data=%h status=%0d ch=%0d fill=%0d eot=%0b",
                                        rsp_data.data_out, rsp_data.status,
                                        rsp_data.channel_out, rsp_data.fill_level,
                                        rsp_data.end_of_transfer));
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_rsp.push_back(pipe_op_result(req_data));
      end
      pending_count = awaited_rsp.size();
   end

endmodule

>>> tb/multi_channel_byte_pipe_unit_tb.sv
// testbench top for the multi-channel byte pipe: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module multi_channel_byte_pipe_unit_tb;
   import mcbp_pkg::*;

   localparam int          RANDOM_ITEMS = 1500;
   localparam int          PHASE_ITEMS  = 150;
   localparam int          MAX_GAP      = 6;
   localparam int          MAX_STALL    = 8;
   localparam int          TAIL_CYCLES  = 20;
   localparam logic [2:0]  FN_SPARE_LO  = 3'd5;
   localparam logic [2:0]  FN_SPARE_HI  = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatch_count;
   int      pending_count;

   // rough view of which channels are open, used only to steer stimulus
   logic [DEF_CHANNELS-1:0] chan_busy = '0;
   int write_pct = 40;
   int read_pct  = 39;

   // receiver stall pattern state
   int stall_mode = 0;
   int mode_left  = 0;
   int stall_run  = 0;

   multi_channel_byte_pipe_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   multi_channel_byte_pipe_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // hard limit on the run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver stalls: phases of none, scattered, and long runs
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(1, MAX_STALL);
            end
         end
      endcase
   end

   function automatic req_type pipe_req(input logic [2:0] fn, input logic [2:0] ch,
                                        input logic [7:0] data, input logic [8:0] size,
                                        input logic last);
      req_type rq;
      rq.func             = fn;
      rq.channel          = ch;
      rq.data_in          = data;
      rq.requested_size   = size;
      rq.last_of_transfer = last;
      return rq;
   endfunction

   // drive one transaction at the falling edge and hold it until accepted
   task automatic issue(input req_type rq);
      int free_ch;
      int size;
      req_data  <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      // track opens and releases for channel selection
      if (rq.func == FN_OPEN) begin
         free_ch = -1;
         for (int c = DEF_CHANNELS - 1; c >= 0; c--) begin
            if (!chan_busy[c]) free_ch = c;
         end
         size = 32'(rq.requested_size & ~SIZE_LOW_MASK);
         if (free_ch >= 0 && size > 1 && size <= DEF_BUF_DEPTH) chan_busy[free_ch] = 1'b1;
      end else if (rq.func == FN_RELEASE) begin
         chan_busy[rq.channel] = 1'b0;
      end
   endtask

   // mostly operations on open channels, with noise on free ones
   task automatic random_request(output req_type rq);
      int pick;
      int open_list [$];
      for (int c = 0; c < DEF_CHANNELS; c++) begin
         if (chan_busy[c]) open_list.push_back(c);
      end
      rq.data_in          = 8'($urandom);
      rq.last_of_transfer = 1'($urandom);
      if (open_list.size() != 0 && $urandom_range(0, 99) < 85)
         rq.channel = 3'(open_list[$urandom_range(0, open_list.size() - 1)]);
      else
         rq.channel = 3'($urandom_range(0, DEF_CHANNELS - 1));
      // small capacities fill up fast, a few large ones and bad sizes
      pick = $urandom_range(0, 99);
      if (pick < 60)
         rq.requested_size = 9'($urandom_range(16, 79));
      else if (pick < 80)
         rq.requested_size = 9'($urandom_range(80, 271));
      else if (pick < 90)
         rq.requested_size = 9'($urandom_range(0, 15));
      else
         rq.requested_size = 9'($urandom_range(272, 511));
      pick = $urandom_range(0, 99);
      if (pick < 8)
         rq.func = FN_OPEN;
      else if (pick < 13)
         rq.func = FN_RELEASE;
      else if (pick < 13 + write_pct)
         rq.func = FN_WRITE;
      else if (pick < 13 + write_pct + read_pct)
         rq.func = FN_READ;
      else if (pick < 17 + write_pct + read_pct)
         rq.func = FN_QUERY;
      else
         rq.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
   endtask

   // stimulus
   initial begin
      req_type rq;
      int      issued;
      int      next_phase;
      int      burst_len;
      int      gap;
      bit      no_gaps;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // operations on channels that are not open
      issue(pipe_req(FN_QUERY,   3'd0, 8'h00, 9'd0, 1'b0));
      issue(pipe_req(FN_READ,    3'd3, 8'h00, 9'd0, 1'b1));
      issue(pipe_req(FN_WRITE,   3'd7, 8'hFF, 9'd0, 1'b0));
      issue(pipe_req(FN_RELEASE, 3'd0, 8'h00, 9'd0, 1'b1));
      // bad sizes: cleared to zero or above the depth
      issue(pipe_req(FN_OPEN, 3'd0, 8'h00, 9'd0,   1'b0));
      issue(pipe_req(FN_OPEN, 3'd5, 8'h00, 9'd15,  1'b1));
      issue(pipe_req(FN_OPEN, 3'd0, 8'h00, 9'd272, 1'b0));
      issue(pipe_req(FN_OPEN, 3'd7, 8'hFF, 9'd511, 1'b1));
      // smallest and largest capacities
      issue(pipe_req(FN_OPEN, 3'd6, 8'h00, 9'd16,  1'b0));
      issue(pipe_req(FN_OPEN, 3'd0, 8'h00, 9'd271, 1'b0));
      // empty read, writes, query and spare code, reads back to empty
      issue(pipe_req(FN_READ,    3'd0, 8'h00, 9'd0, 1'b0));
      issue(pipe_req(FN_WRITE,   3'd0, 8'h00, 9'd0, 1'b1));
      issue(pipe_req(FN_WRITE,   3'd0, 8'hFF, 9'd0, 1'b0));
      issue(pipe_req(FN_WRITE,   3'd1, 8'hA5, 9'd0, 1'b1));
      issue(pipe_req(FN_QUERY,   3'd0, 8'h00, 9'd0, 1'b0));
      issue(pipe_req(FN_SPARE_HI, 3'd1, 8'h00, 9'd0, 1'b1));
      issue(pipe_req(FN_READ,    3'd0, 8'h00, 9'd0, 1'b0));
      issue(pipe_req(FN_READ,    3'd0, 8'h00, 9'd0, 1'b1));
      issue(pipe_req(FN_READ,    3'd0, 8'h00, 9'd0, 1'b0));
      // take every channel, then one open too many
      for (int c = 2; c < DEF_CHANNELS; c++)
         issue(pipe_req(FN_OPEN, 3'd0, 8'h00, 9'd32, 1'b0));
      issue(pipe_req(FN_OPEN, 3'd0, 8'h00, 9'd64, 1'b1));
      // release frees the channel, a second release finds it closed
      issue(pipe_req(FN_RELEASE, 3'd7, 8'h00, 9'd0, 1'b0));
      issue(pipe_req(FN_RELEASE, 3'd7, 8'h00, 9'd0, 1'b1));

      // random part in bursts, with phases biased toward filling or draining
      issued     = 0;
      next_phase = 0;
      while (issued < RANDOM_ITEMS) begin
         if (issued >= next_phase) begin
            case ($urandom_range(0, 2))
               0: begin write_pct = 55; read_pct = 24; end
               1: begin write_pct = 24; read_pct = 55; end
               default: begin write_pct = 40; read_pct = 39; end
            endcase
            no_gaps    = ($urandom_range(0, 3) == 0);
            next_phase = next_phase + PHASE_ITEMS;
         end
         burst_len = $urandom_range(1, 20);
         for (int b = 0; b < burst_len && issued < RANDOM_ITEMS; b++) begin
            random_request(rq);
            issue(rq);
            issued++;
         end
         gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      // drain outstanding responses, then allow for late extras
      while (pending_count != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
sv/mcbp_pkg.sv
sv/mcbp_byte_ram.sv
sv/mcbp_chan_table.sv
sv/mcbp_ctrl.sv
sv/multi_channel_byte_pipe_unit.sv
tb/multi_channel_byte_pipe_checker.sv
tb/multi_channel_byte_pipe_unit_tb.sv
